// ===== src/slasm_pkg.sv =====
// ----------------------------------------------------------------------------
// slasm_pkg
// Shared constants and types for the serial line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package slasm_pkg;

    // default size of one line store bank, in bytes
    localparam int LINE_STORE_BYTES_DEF = 32;

    // byte and configuration widths
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 8;

    // line terminators
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    // reset value of the destination buffer size
    localparam logic [CFG_W-1:0] DEST_SIZE_RESET = 8'd32;

    // back end tells the front end that a bank is free again
    typedef struct packed {
        logic done;
        logic bank;
    } slasm_release_t;

endpackage

`default_nettype wire

// ===== src/serial_line_assembler_top.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler_top
// Collects received bytes into lines ended by CR or LF and delivers each
// line as a run of bytes with a last marker.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one received byte per request. Bytes go into one of two
//   line store banks; CR or LF closes a non-empty line, an empty one is
//   dropped, and a byte arriving on a full line discards that line.
//   m_* channel delivers the closed line: bytes in order, cut at
//   cfg_wdata-1 bytes and before the first zero byte, m_last on the final
//   one; if nothing remains, one request with m_empty_line set.
//   The user must write the destination size register through cfg_we/cfg_wdata
//   only while the block is idle; the block does not enforce it. It resets to 32.
//   After a terminator the readout pops the queue; for each byte it then steps
//   through fetch (RAM read), load into the output register and send, and it
//   does not fetch the next byte until the current one is taken.
//   While the readout unit works on one bank, the input side keeps filling
//   the other; s_ready drops only when both banks hold lines not yet read
//   out. A stalled m_ready holds the output register and stalls the readout
//   only. Reset empties both banks and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler_top import slasm_pkg::*; #(
    parameter int LINE_STORE_BYTES = LINE_STORE_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // received byte channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_rx_byte,
    // line byte channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_line_byte,
    output logic                   m_last,
    output logic                   m_empty_line,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(LINE_STORE_BYTES);

    logic              st_wr_en;
    logic [AW:0]       st_wr_addr;
    logic [BYTE_W-1:0] st_wr_data;
    logic              st_rd_en;
    logic [AW:0]       st_rd_addr;
    logic [BYTE_W-1:0] st_rd_data;

    logic              cmd_push;
    logic [AW:0]       cmd_push_data;
    logic              cmd_pop;
    logic [AW:0]       cmd_pop_data;
    logic              cmd_full;
    logic              cmd_empty;

    slasm_release_t    bank_release;

    // input side
    slasm_front #(
        .LINE_STORE_BYTES(LINE_STORE_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_push_data),
        .cmd_full   (cmd_full),
        .release_in (bank_release)
    );

    // two line store banks, each padded to a power of two so that the bank
    // bit sits on top of the byte address
    slasm_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(2 << AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // closed-line queue
    slasm_fifo #(
        .WIDTH(AW + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .pop       (cmd_pop),
        .pop_data  (cmd_pop_data),
        .full      (cmd_full),
        .empty     (cmd_empty)
    );

    // readout side
    slasm_back #(
        .LINE_STORE_BYTES(LINE_STORE_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_pop      (cmd_pop),
        .cmd_data     (cmd_pop_data),
        .cmd_empty    (cmd_empty),
        .st_rd_en     (st_rd_en),
        .st_rd_addr   (st_rd_addr),
        .st_rd_data   (st_rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_byte  (m_line_byte),
        .m_last       (m_last),
        .m_empty_line (m_empty_line),
        .release_out  (bank_release)
    );

endmodule

`default_nettype wire

// ===== src/slasm_ram.sv =====
// ----------------------------------------------------------------------------
// slasm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slasm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/slasm_fifo.sv =====
// ----------------------------------------------------------------------------
// slasm_fifo
// Two-entry queue carrying completed line commands from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

module slasm_fifo #(
    parameter int WIDTH = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push && !full, pop && !empty})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/slasm_front.sv =====
// ----------------------------------------------------------------------------
// slasm_front
// Accepts received bytes, fills the current store bank and tracks the first
// zero byte; on a terminator closing a non-empty line it queues the bank with its delivery length.
// ----------------------------------------------------------------------------
`default_nettype none

module slasm_front import slasm_pkg::*; #(
    parameter int LINE_STORE_BYTES = LINE_STORE_BYTES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // byte request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [BYTE_W-1:0]                   s_rx_byte,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [CFG_W-1:0]                    cfg_wdata,
    // store write port
    output logic                                     st_wr_en,
    output logic [$clog2(LINE_STORE_BYTES):0]        st_wr_addr,
    output logic [BYTE_W-1:0]                        st_wr_data,
    // command queue
    output logic                                     cmd_push,
    output logic [$clog2(LINE_STORE_BYTES):0]        cmd_data,
    input  wire logic                                cmd_full,
    // bank release from the back end
    input  wire slasm_release_t                      release_in
);

    localparam int AW = $clog2(LINE_STORE_BYTES);
    localparam int LW = CFG_W + 1;

    logic [AW-1:0]    fill_reg, fill_next;
    logic             zseen_reg, zseen_next;
    logic [AW-1:0]    zpos_reg, zpos_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [CFG_W-1:0] dest_reg;

    logic             accept;
    logic             is_term;
    logic             store_full;
    logic [AW-1:0]    run_base;
    logic [CFG_W-1:0] limit;
    logic [AW-1:0]    run_len;

    assign s_ready    = !busy_reg[bank_reg] && !cmd_full;
    assign accept     = s_valid && s_ready;
    assign is_term    = (s_rx_byte == CH_LF) || (s_rx_byte == CH_CR);
    assign store_full = (fill_reg == AW'(LINE_STORE_BYTES - 1));

    // delivery length: stored bytes up to the first zero, capped by the limit
    assign run_base = zseen_reg ? zpos_reg : fill_reg;
    assign limit    = dest_reg - CFG_W'(1);
    assign run_len  = (LW'(run_base) < LW'(limit)) ? run_base : limit[AW-1:0];

    // store write and command push
    assign st_wr_en   = accept && !is_term && !store_full;
    assign st_wr_addr = {bank_reg, fill_reg};
    assign st_wr_data = s_rx_byte;
    assign cmd_push   = accept && is_term && (fill_reg != '0);
    assign cmd_data   = {bank_reg, run_len};

    // line tracking
    always_comb begin
        fill_next  = fill_reg;
        zseen_next = zseen_reg;
        zpos_next  = zpos_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (release_in.done) begin
            busy_next[release_in.bank] = 1'b0;
        end
        if (accept) begin
            if (is_term || store_full) begin
                fill_next  = '0;
                zseen_next = 1'b0;
            end else begin
                fill_next = fill_reg + AW'(1);
                if (s_rx_byte == '0 && !zseen_reg) begin
                    zseen_next = 1'b1;
                    zpos_next  = fill_reg;
                end
            end
        end
        if (cmd_push) begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = ~bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            zseen_reg <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end else begin
            fill_reg  <= fill_next;
            zseen_reg <= zseen_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        zpos_reg <= zpos_next;
    end

    // destination size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg <= DEST_SIZE_RESET;
        end else if (cfg_we) begin
            dest_reg <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/slasm_back.sv =====
// ----------------------------------------------------------------------------
// slasm_back
// Takes queued line commands and reads the bank out one byte at a time into
// the output register, marking the last byte or an empty line.
// ----------------------------------------------------------------------------
`default_nettype none

module slasm_back import slasm_pkg::*; #(
    parameter int LINE_STORE_BYTES = LINE_STORE_BYTES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // command queue
    output logic                                     cmd_pop,
    input  wire logic [$clog2(LINE_STORE_BYTES):0]   cmd_data,
    input  wire logic                                cmd_empty,
    // store read port
    output logic                                     st_rd_en,
    output logic [$clog2(LINE_STORE_BYTES):0]        st_rd_addr,
    input  wire logic [BYTE_W-1:0]                   st_rd_data,
    // result request channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [BYTE_W-1:0]                        m_line_byte,
    output logic                                     m_last,
    output logic                                     m_empty_line,
    // bank release to the front end
    output slasm_release_t                           release_out
);

    localparam int AW = $clog2(LINE_STORE_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_SEND  = 4'b1000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;

    assign cmd_pop    = (state_reg == ST_IDLE) && !cmd_empty;
    assign st_rd_en   = (state_reg == ST_FETCH);
    assign st_rd_addr = {bank_reg, idx_reg};

    assign m_valid      = valid_reg;
    assign m_line_byte  = byte_reg;
    assign m_last       = last_reg;
    assign m_empty_line = empty_reg;

    assign release_out.done = (state_reg == ST_SEND) && m_ready && last_reg;
    assign release_out.bank = bank_reg;

    // readout sequencer
    always_comb begin
        state_next = state_reg;
        bank_next  = bank_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        empty_next = empty_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    bank_next = cmd_data[AW];
                    cnt_next  = cmd_data[AW-1:0];
                    idx_next  = '0;
                    if (cmd_data[AW-1:0] == '0) begin
                        // nothing left after the cut: report an empty line
                        valid_next = 1'b1;
                        byte_next  = '0;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        state_next = ST_SEND;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                valid_next = 1'b1;
                byte_next  = st_rd_data;
                last_next  = (idx_reg == cnt_reg - AW'(1));
                empty_next = 1'b0;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bank_reg  <= bank_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

endmodule

`default_nettype wire

// ===== dv/serial_line_assembler_top_tb.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler_top_tb
// Feeds received bytes to the serial line assembler and checks every
// delivered line byte against a line predictor kept in the bench: CR/LF
// line closing, empty line drop, full store discard, the cut at the
// destination size and at the first zero byte, under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler_top_tb;
    import slasm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES   = LINE_STORE_BYTES_DEF;
    localparam int SETTLE_CYCLES = 3 * STORE_BYTES + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 130;

    // one delivered line byte
    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              last;
        logic              empty_line;
    } line_out_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte    = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [BYTE_W-1:0] m_line_byte;
    logic              m_last;
    logic              m_empty_line;
    logic              cfg_we       = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata    = '0;

    // predictor state
    logic [BYTE_W-1:0] line_mem [STORE_BYTES];
    int                line_fill = 0;
    logic [CFG_W-1:0]  dest_size = DEST_SIZE_RESET;
    line_out_t         due_line_bytes [$];

    int err_count   = 0;
    int cycle_count = 0;
    bit idle_on     = 1'b0;
    int rx_hold_req = 0;
    int ready_gap   = 0;

    serial_line_assembler_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_byte  (m_line_byte),
        .m_last       (m_last),
        .m_empty_line (m_empty_line),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d line bytes still due",
                     cycle_count, due_line_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // payload byte that never closes a line
    function automatic logic [BYTE_W-1:0] pick_text_byte(bit allow_zero);
        logic [BYTE_W-1:0] b;
        if (allow_zero && $urandom_range(0, 19) == 0)
            return '0;
        do begin
            b = BYTE_W'($urandom_range(1, 255));
        end while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    // line predictor: store, close and cut, queue the delivered bytes
    task automatic assemble_byte(input logic [BYTE_W-1:0] b);
        int        n;
        logic [CFG_W-1:0] cut;
        line_out_t o;
        if (b != CH_LF && b != CH_CR) begin
            if (line_fill < STORE_BYTES - 1) begin
                line_mem[line_fill] = b;
                line_fill++;
            end else begin
                line_fill = 0;
            end
        end else if (line_fill != 0) begin
            cut = dest_size - 1'b1;
            n = 0;
            while (n < line_fill && n < int'(cut) && line_mem[n] != '0)
                n++;
            line_fill = 0;
            if (n == 0) begin
                o = '{line_byte: '0, last: 1'b1, empty_line: 1'b1};
                due_line_bytes.push_back(o);
            end else begin
                for (int k = 0; k < n; k++) begin
                    o = '{line_byte: line_mem[k], last: (k == n - 1), empty_line: 1'b0};
                    due_line_bytes.push_back(o);
                end
            end
        end
    endtask

    // one request on the received byte channel
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        assemble_byte(b);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // CR, LF or CR LF
    task automatic send_terminator();
        case ($urandom_range(0, 2))
            0: send_byte(CH_CR);
            1: send_byte(CH_LF);
            default: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
        endcase
    endtask

    task automatic send_line(input int len, input bit allow_zero);
        for (int i = 0; i < len; i++)
            send_byte(pick_text_byte(allow_zero));
        send_terminator();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (due_line_bytes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_dest_size(input logic [CFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        dest_size = v;
    endtask

    // result receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_hold_req != 0) begin
                ready_gap   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (ready_gap > 0) begin
                m_ready <= 1'b0;
                ready_gap--;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 2) == 0)
                    ready_gap = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        line_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_line_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected line byte %02h last %0b empty %0b",
                                          m_line_byte, m_last, m_empty_line));
            end else begin
                want = due_line_bytes.pop_front();
                if (m_empty_line !== want.empty_line)
                    report_mismatch($sformatf("empty_line %0b, want %0b",
                                              m_empty_line, want.empty_line));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
                if (!want.empty_line && m_line_byte !== want.line_byte)
                    report_mismatch($sformatf("line_byte %02h, want %02h",
                                              m_line_byte, want.line_byte));
            end
        end
    end

    // terminators on an empty store, CR LF, byte extremes, zero byte cut
    task automatic test_directed();
        logic [BYTE_W-1:0] seq [$];
        seq = '{CH_LF, CH_CR,
                8'h41, CH_CR, CH_LF,
                8'hFF, 8'h01, 8'h7F, 8'h80, CH_LF,
                8'h00, 8'h42, CH_CR,
                8'h43, 8'h00, 8'h44, CH_LF,
                8'h09, 8'h0B, 8'h0C, 8'h0E, CH_CR};
        idle_on = 1'b0;
        foreach (seq[i])
            send_byte(seq[i]);
        wait_drained();
    endtask

    // full store, then a discarded line and what follows it
    task automatic test_store_full();
        idle_on = 1'b1;
        send_line(STORE_BYTES - 1, 1'b0);
        for (int i = 0; i < STORE_BYTES; i++)
            send_byte(pick_text_byte(1'b0));
        send_byte(8'h5A);
        send_byte(CH_LF);
        for (int i = 0; i < STORE_BYTES; i++)
            send_byte(pick_text_byte(1'b0));
        send_byte(CH_CR);
        wait_drained();
    endtask

    // destination size sweep, extremes included
    task automatic test_dest_sizes();
        logic [CFG_W-1:0] sizes [$];
        sizes = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd5, 8'd31, 8'd32, 8'd33};
        idle_on = 1'b1;
        foreach (sizes[i]) begin
            write_dest_size(sizes[i]);
            send_line($urandom_range(1, 8), 1'b0);
            if (sizes[i] == 8'd0 || sizes[i] == 8'd31 || sizes[i] == 8'd255)
                send_line(STORE_BYTES - 1, 1'b0);
        end
        wait_drained();
    endtask

    // mostly well-formed lines with random content, some noise
    task automatic test_random();
        int items;
        int len;
        idle_on = 1'b1;
        write_dest_size(CFG_W'($urandom_range(2, 40)));
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if (items >= RANDOM_ITEMS / 2 && dest_size != 8'd0 && $urandom_range(0, 9) == 0)
                write_dest_size(CFG_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) != 0) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 34)
                                                  : $urandom_range(0, 10);
                send_line(len, 1'b1);
                items += len + 1;
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
                items++;
            end
        end
        send_byte(CH_LF);
        wait_drained();
    endtask

    // long receiver hold-off fills both banks; then a drained pause
    task automatic test_pressure();
        write_dest_size(DEST_SIZE_RESET);
        idle_on = 1'b0;
        rx_hold_req = 500;
        @(posedge aclk);
        for (int i = 0; i < 3; i++)
            send_line(20, 1'b0);
        send_line(5, 1'b0);
        wait_drained();
        idle_on = 1'b1;
        for (int i = 0; i < 6; i++)
            send_byte(pick_text_byte(1'b1));
        wait_drained();
        send_line($urandom_range(1, 12), 1'b1);
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_store_full();
        test_dest_sizes();
        test_random();
        test_pressure();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/slasm_pkg.sv
src/slasm_ram.sv
src/slasm_fifo.sv
src/slasm_front.sv
src/slasm_back.sv
src/serial_line_assembler_top.sv
dv/serial_line_assembler_top_tb.sv
